/* rtl/dte_pkg.sv */
// shared constants, command codes and job type for the dictionary token expander
`timescale 1ns / 1ps

package dte_pkg;

   localparam int TOKEN_BITS      = 16;
   localparam int DICT_BYTES      = 2097152;
   localparam int MAX_ENTRY_BYTES = 64;

   localparam int TOKEN_COUNT = 2 ** TOKEN_BITS;
   localparam int BOUND_DEPTH = TOKEN_COUNT + 1;
   localparam int BIDX_W      = $clog2(BOUND_DEPTH);
   localparam int BOUND_W     = 22;
   localparam int DICT_AW     = $clog2(DICT_BYTES);
   localparam int SPAN_W      = BOUND_W + 1;
   localparam int CNT_W       = $clog2(MAX_ENTRY_BYTES + 1);

   localparam int JQ_DEPTH = 4;
   localparam int JQ_AW    = $clog2(JQ_DEPTH);
   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);

   localparam logic [1:0] CMD_BYTE   = 2'd0;
   localparam logic [1:0] CMD_BOUND  = 2'd1;
   localparam logic [1:0] CMD_DECODE = 2'd2;

   localparam logic JOB_WRITE  = 1'b0;
   localparam logic JOB_EXPAND = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [BOUND_W-1:0] addr;
      logic [7:0]         value;
      logic [CNT_W-1:0]   count;
      logic               cut;
   } job_type;

endpackage

/* rtl/dte_queue.sv */
// job queue between the request front end and the expansion back end
`timescale 1ns / 1ps

module dte_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_push,
   output logic             q_full,
   input  dte_pkg::job_type q_wdata,
   input  logic             q_pop,
   output logic             q_empty,
   output dte_pkg::job_type q_rdata
);

   dte_pkg::job_type slot_ff [0:dte_pkg::JQ_DEPTH-1];

   logic [dte_pkg::JQ_AW-1:0] wptr_ff, wptr_in;
   logic [dte_pkg::JQ_AW-1:0] rptr_ff, rptr_in;
   logic [dte_pkg::JQ_AW:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign q_full  = (count_ff == (dte_pkg::JQ_AW+1)'(dte_pkg::JQ_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_rdata = slot_ff[rptr_ff];

   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (dte_pkg::JQ_AW+1)'(do_push) - (dte_pkg::JQ_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= q_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (dte_pkg::JQ_AW+1)'(dte_pkg::JQ_DEPTH))
      else $error("job queue count beyond depth");

endmodule

/* rtl/dte_front.sv */
// request front end: boundary table, span lookup and job classification
`timescale 1ns / 1ps

module dte_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [1:0]                   req_cmd,
   input  logic [20:0]                  req_byte_addr,
   input  logic [7:0]                   req_byte_value,
   input  logic [16:0]                  req_entry_index,
   input  logic [21:0]                  req_entry_bound,
   input  logic [15:0]                  req_token,
   output logic                         q_push,
   input  logic                         q_full,
   output dte_pkg::job_type             q_wdata
);

   logic [dte_pkg::BOUND_W-1:0] bound_mem [0:dte_pkg::BOUND_DEPTH-1];

   logic [dte_pkg::BOUND_W-1:0] start_ff, end_ff;
   logic                        s1_valid_ff, s1_valid_in;
   logic [1:0]                  s1_cmd_ff;
   logic [20:0]                 s1_addr_ff;
   logic [7:0]                  s1_value_ff;

   logic                        accept, s1_go;
   logic [dte_pkg::BIDX_W-1:0]  tok_idx, tok_next;
   logic                        span_ok, cut;
   logic [dte_pkg::BOUND_W-1:0] span_len;
   logic [dte_pkg::CNT_W-1:0]   count;

   assign tok_idx  = dte_pkg::BIDX_W'(req_token[dte_pkg::TOKEN_BITS-1:0]);
   assign tok_next = tok_idx + dte_pkg::BIDX_W'(1);

   // span of the looked-up entry
   assign span_ok  = end_ff > start_ff;
   assign span_len = end_ff - start_ff;
   assign cut      = span_len > dte_pkg::BOUND_W'(dte_pkg::MAX_ENTRY_BYTES);
   assign count    = cut ? dte_pkg::CNT_W'(dte_pkg::MAX_ENTRY_BYTES)
                         : span_len[dte_pkg::CNT_W-1:0];

   assign q_push = s1_valid_ff && ((s1_cmd_ff == dte_pkg::CMD_BYTE) || span_ok);
   assign s1_go  = !s1_valid_ff || !q_push || !q_full;
   assign full   = !s1_go;
   assign accept = push && !full;

   always_comb begin
      q_wdata       = '0;
      q_wdata.value = s1_value_ff;
      if (s1_cmd_ff == dte_pkg::CMD_BYTE) begin
         q_wdata.kind = dte_pkg::JOB_WRITE;
         q_wdata.addr = dte_pkg::BOUND_W'(s1_addr_ff);
      end else begin
         q_wdata.kind  = dte_pkg::JOB_EXPAND;
         q_wdata.addr  = start_ff;
         q_wdata.count = count;
         q_wdata.cut   = cut;
      end
   end

   always_comb begin
      if (s1_go) begin
         s1_valid_in = accept && ((req_cmd == dte_pkg::CMD_BYTE) ||
                                  (req_cmd == dte_pkg::CMD_DECODE));
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_cmd == dte_pkg::CMD_BOUND) &&
          (req_entry_index <= dte_pkg::BIDX_W'(dte_pkg::TOKEN_COUNT))) begin
         bound_mem[req_entry_index] <= req_entry_bound;
      end
      if (accept && (req_cmd == dte_pkg::CMD_DECODE)) begin
         start_ff <= bound_mem[tok_idx];
         end_ff   <= bound_mem[tok_next];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff   <= req_cmd;
         s1_addr_ff  <= req_byte_addr;
         s1_value_ff <= req_byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

endmodule

/* rtl/dte_back.sv */
// expansion back end: dictionary byte store, byte sequencer and result buffer
`timescale 1ns / 1ps

module dte_back (
   input  logic             clock,
   input  logic             reset,
   output logic             q_pop,
   input  logic             q_empty,
   input  dte_pkg::job_type q_rdata,
   output logic             empty,
   input  logic             pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic             rsp_truncated
);

   logic [7:0] dict_mem [0:dte_pkg::DICT_BYTES-1];
   logic [7:0] rd_data_ff;

   logic                       active_ff, active_in;
   logic [dte_pkg::SPAN_W-1:0] addr_ff, addr_in;
   logic [dte_pkg::CNT_W-1:0]  remain_ff, remain_in;
   logic                       cut_ff, cut_in;

   logic pend_ff, pend_in;
   logic pend_last_ff, pend_last_in;
   logic pend_trunc_ff, pend_trunc_in;
   logic pend_oob_ff, pend_oob_in;

   logic [7:0] ob_byte_ff  [0:dte_pkg::OQ_DEPTH-1];
   logic       ob_last_ff  [0:dte_pkg::OQ_DEPTH-1];
   logic       ob_trunc_ff [0:dte_pkg::OQ_DEPTH-1];

   logic [dte_pkg::OQ_AW-1:0] ob_wptr_ff, ob_wptr_in;
   logic [dte_pkg::OQ_AW-1:0] ob_rptr_ff, ob_rptr_in;
   logic [dte_pkg::OQ_AW:0]   ob_occ_ff, ob_occ_in;

   logic wr_en, issue, is_last, oob, out_fire, room;
   logic [dte_pkg::OQ_AW:0] committed;

   assign q_pop = !active_ff && !q_empty;
   assign wr_en = q_pop && (q_rdata.kind == dte_pkg::JOB_WRITE) &&
                  (q_rdata.addr < dte_pkg::BOUND_W'(dte_pkg::DICT_BYTES));

   // result slots held or already in flight from the store
   assign committed = ob_occ_ff + (dte_pkg::OQ_AW+1)'(pend_ff);
   assign room      = committed < (dte_pkg::OQ_AW+1)'(dte_pkg::OQ_DEPTH);
   assign issue     = active_ff && room;
   assign is_last   = (remain_ff == dte_pkg::CNT_W'(1));
   assign oob       = addr_ff >= dte_pkg::SPAN_W'(dte_pkg::DICT_BYTES);

   assign empty         = (ob_occ_ff == '0);
   assign out_fire      = pop && !empty;
   assign rsp_out_byte  = ob_byte_ff[ob_rptr_ff];
   assign rsp_last      = ob_last_ff[ob_rptr_ff];
   assign rsp_truncated = ob_trunc_ff[ob_rptr_ff];

   always_comb begin
      active_in = active_ff;
      addr_in   = addr_ff;
      remain_in = remain_ff;
      cut_in    = cut_ff;
      if (q_pop && (q_rdata.kind == dte_pkg::JOB_EXPAND)) begin
         active_in = 1'b1;
         addr_in   = dte_pkg::SPAN_W'(q_rdata.addr);
         remain_in = q_rdata.count;
         cut_in    = q_rdata.cut;
      end else if (issue) begin
         addr_in   = addr_ff + dte_pkg::SPAN_W'(1);
         remain_in = remain_ff - dte_pkg::CNT_W'(1);
         if (is_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_comb begin
      pend_in       = issue;
      pend_last_in  = is_last;
      pend_trunc_in = is_last && cut_ff;
      pend_oob_in   = oob;
      ob_wptr_in    = pend_ff ? ob_wptr_ff + 1'b1 : ob_wptr_ff;
      ob_rptr_in    = out_fire ? ob_rptr_ff + 1'b1 : ob_rptr_ff;
      ob_occ_in     = ob_occ_ff + (dte_pkg::OQ_AW+1)'(pend_ff)
                      - (dte_pkg::OQ_AW+1)'(out_fire);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dict_mem[q_rdata.addr[dte_pkg::DICT_AW-1:0]] <= q_rdata.value;
      end
      if (issue) begin
         rd_data_ff <= dict_mem[addr_ff[dte_pkg::DICT_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         ob_byte_ff[ob_wptr_ff]  <= pend_oob_ff ? 8'd0 : rd_data_ff;
         ob_last_ff[ob_wptr_ff]  <= pend_last_ff;
         ob_trunc_ff[ob_wptr_ff] <= pend_trunc_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      remain_ff     <= remain_in;
      cut_ff        <= cut_in;
      pend_last_ff  <= pend_last_in;
      pend_trunc_ff <= pend_trunc_in;
      pend_oob_ff   <= pend_oob_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         pend_ff    <= 1'b0;
         ob_wptr_ff <= '0;
         ob_rptr_ff <= '0;
         ob_occ_ff  <= '0;
      end else begin
         active_ff  <= active_in;
         pend_ff    <= pend_in;
         ob_wptr_ff <= ob_wptr_in;
         ob_rptr_ff <= ob_rptr_in;
         ob_occ_ff  <= ob_occ_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (ob_occ_ff < (dte_pkg::OQ_AW+1)'(dte_pkg::OQ_DEPTH)))
      else $error("store read in flight with no free result slot");

   assert property (@(posedge clock) disable iff (reset)
      pend_ff && pend_trunc_ff |-> pend_last_ff)
      else $error("truncation flag on a byte that is not last");

   assert property (@(posedge clock) disable iff (reset)
      issue && is_last |=> !active_ff)
      else $error("sequencer still busy after its last byte");

   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (remain_ff != '0))
      else $error("sequencer busy with no bytes left");

endmodule

/* rtl/dictionary_token_expander.sv */
// top level of the dictionary token expander
// a decode's first byte passes the front-end stage, job queue, sequencer and store read register
// throughput: one request per cycle at the front while the job queue has room; one result byte
// per cycle while expanding and the result buffer has room; a new job waits for an idle sequencer
// the single-port byte store and the byte sequencer set the sustained token rate
// reset clears control state only; dictionary and boundary contents stay undefined until written
`timescale 1ns / 1ps

module dictionary_token_expander (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [20:0] req_byte_addr,
   input  logic [7:0]  req_byte_value,
   input  logic [16:0] req_entry_index,
   input  logic [21:0] req_entry_bound,
   input  logic [15:0] req_token,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic        rsp_truncated
);

   logic             jq_push, jq_full, jq_pop, jq_empty;
   dte_pkg::job_type jq_wdata, jq_rdata;

   dte_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_cmd         (req_cmd),
      .req_byte_addr   (req_byte_addr),
      .req_byte_value  (req_byte_value),
      .req_entry_index (req_entry_index),
      .req_entry_bound (req_entry_bound),
      .req_token       (req_token),
      .q_push          (jq_push),
      .q_full          (jq_full),
      .q_wdata         (jq_wdata)
   );

   dte_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (jq_push),
      .q_full  (jq_full),
      .q_wdata (jq_wdata),
      .q_pop   (jq_pop),
      .q_empty (jq_empty),
      .q_rdata (jq_rdata)
   );

   dte_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_pop         (jq_pop),
      .q_empty       (jq_empty),
      .q_rdata       (jq_rdata),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .rsp_truncated (rsp_truncated)
   );

endmodule
